/* design/mhpq_pkg.sv */
`timescale 1ns / 1ps

package mhpq_pkg;

   localparam int HEAP_CAPACITY = 128;
   localparam int KEY_WIDTH     = 32;

   // Slot address, element count (holds the capacity itself) and child index widths.
   localparam int ADDR_W = $clog2(HEAP_CAPACITY);
   localparam int CNT_W  = $clog2(HEAP_CAPACITY + 1);
   localparam int IDX_W  = ADDR_W + 1;

   // Port field widths are fixed by the interface.
   localparam int PORT_KEY_W = 32;
   localparam int MOVES_W    = 3;
   localparam int OCC_W      = 8;
   localparam int RSP_DATA_W = 48;

   typedef logic signed [KEY_WIDTH-1:0] key_type;
   typedef logic [ADDR_W-1:0]           addr_type;
   typedef logic [CNT_W-1:0]            count_type;
   typedef logic [IDX_W-1:0]            idx_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP,
      ST_DN_LOAD,
      ST_DN,
      ST_PLACE,
      ST_DONE
   } state_type;

endpackage

/* design/max_heap_priority_queue.sv */
`timescale 1ns / 1ps

// Channel   Dir  Ports                       Beat contents
// -------   ---  --------------------------  -------------------------------------------
// request   in   req_tvalid/tready/tdata/    tuser: operation (0 insert, 1 delete max);
//                tuser                       tdata: signed key
// response  out  rsp_tvalid/tready/tdata/    tuser: status; tdata: removed key, swap
//                tuser                       count, occupancy
//
// The heap lives in one synchronous RAM with one write port and two read ports, read data
// registered. During a sift the compare uses the data read in the previous cycle while
// the next level's read is issued, and a sift makes at most 7 swaps for 128 slots. An
// insert into the empty heap, a full insert and an empty delete go straight to the done
// state; deleting the only key passes only through the load state on its way there.
// Reset clears the count, the control state and the response valid flag only; the RAM
// needs no clearing because data read from slots at or above the count is never used.
// A new request is accepted once the previous result has been loaded into the response
// register, even while that response is still stalled; a finished result waits in the
// done state until the response register is free.

module max_heap_priority_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] key
   input  logic        req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [31:0] removed_key, [34:32] swap_moves,
                                    // [42:35] occupancy, [47:43] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);
   import mhpq_pkg::*;

   // Heap RAM.
   key_type  heap_mem [HEAP_CAPACITY];
   key_type  mem_rd_a_ff, mem_rd_b_ff;
   addr_type rd_a_addr, rd_b_addr, wr_addr;
   logic     wr_en;
   key_type  wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      mem_rd_a_ff <= heap_mem[rd_a_addr];
      mem_rd_b_ff <= heap_mem[rd_b_addr];
   end

   // Control and datapath registers.
   state_type            state_ff, state_in;
   count_type            count_ff, count_in;
   addr_type             pos_ff, pos_in;
   key_type              key_ff, key_in;      // the key being sifted
   key_type              top_ff, top_in;      // removed root, zero when none
   logic [MOVES_W-1:0]   moves_ff, moves_in;
   status_type           status_ff, status_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]           rsp_user_ff, rsp_user_in;

   logic req_fire;
   logic out_free;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Sift-up helpers: parent of the current slot and of the new slot.
   addr_type up_par, ins_par;
   assign up_par  = (pos_ff - addr_type'(1)) >> 1;
   assign ins_par = (addr_type'(count_ff) - addr_type'(1)) >> 1;

   // Sift-down helpers.
   idx_type  dn_l, dn_r, dn_big, dn_nl;
   logic     dn_l_ok, dn_r_ok;
   key_type  dn_big_val;
   assign dn_l = {pos_ff, 1'b1};
   assign dn_r = {pos_ff, 1'b0} + idx_type'(2);
   assign dn_l_ok = dn_l < idx_type'(count_ff);
   assign dn_r_ok = dn_r < idx_type'(count_ff);

   // Larger child wins; the left child wins a tie because the right must be strictly larger.
   always_comb begin
      dn_big     = idx_type'(pos_ff);
      dn_big_val = key_ff;
      if (dn_l_ok && (mem_rd_a_ff > dn_big_val)) begin
         dn_big     = dn_l;
         dn_big_val = mem_rd_a_ff;
      end
      if (dn_r_ok && (mem_rd_b_ff > dn_big_val)) begin
         dn_big     = dn_r;
         dn_big_val = mem_rd_b_ff;
      end
   end

   assign dn_nl = {dn_big[ADDR_W-1:0], 1'b1};

   logic [MOVES_W-1:0] moves_inc;
   assign moves_inc = (&moves_ff) ? moves_ff : moves_ff + MOVES_W'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (op_type'(req_tuser) == OP_INSERT) begin
                  if ((count_ff == count_type'(HEAP_CAPACITY)) || (count_ff == '0)) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_UP;
                  end
               end else begin
                  state_in = (count_ff == '0) ? ST_DONE : ST_DN_LOAD;
               end
            end
         end
         ST_UP: begin
            if (key_ff > mem_rd_a_ff) begin
               state_in = (up_par == '0) ? ST_PLACE : ST_UP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DN_LOAD: begin
            if (count_ff == '0) begin
               state_in = ST_DONE;
            end else if (count_ff > count_type'(1)) begin
               state_in = ST_DN;
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_DN: begin
            if (dn_big == idx_type'(pos_ff)) begin
               state_in = ST_DONE;
            end else begin
               state_in = (dn_nl < idx_type'(count_ff)) ? ST_DN : ST_PLACE;
            end
         end
         ST_PLACE: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // RAM controls and datapath updates.
   always_comb begin
      count_in     = count_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      top_in       = top_ff;
      moves_in     = moves_ff;
      status_in    = status_ff;
      rd_a_addr    = '0;
      rd_b_addr    = '0;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               moves_in  = '0;
               top_in    = '0;
               status_in = STATUS_OK;
               key_in    = key_type'(req_tdata);
               if (op_type'(req_tuser) == OP_INSERT) begin
                  if (count_ff == count_type'(HEAP_CAPACITY)) begin
                     status_in = STATUS_FULL;
                  end else if (count_ff == '0) begin
                     // First key goes straight to the root.
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     wr_data  = key_type'(req_tdata);
                     count_in = count_type'(1);
                  end else begin
                     pos_in    = addr_type'(count_ff);
                     rd_a_addr = ins_par;
                     count_in  = count_ff + count_type'(1);
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     // Fetch the root and the last element together.
                     rd_a_addr = '0;
                     rd_b_addr = addr_type'(count_ff - count_type'(1));
                     count_in  = count_ff - count_type'(1);
                  end
               end
            end
         end
         ST_UP: begin
            if (key_ff > mem_rd_a_ff) begin
               // Move the parent down into the hole and climb.
               wr_en     = 1'b1;
               wr_data   = mem_rd_a_ff;
               pos_in    = up_par;
               moves_in  = moves_inc;
               rd_a_addr = (up_par - addr_type'(1)) >> 1;
            end else begin
               wr_en = 1'b1;
            end
         end
         ST_DN_LOAD: begin
            top_in    = mem_rd_a_ff;
            key_in    = mem_rd_b_ff;
            pos_in    = '0;
            rd_a_addr = addr_type'(1);
            rd_b_addr = addr_type'(2);
         end
         ST_DN: begin
            wr_en = 1'b1;
            if (dn_big != idx_type'(pos_ff)) begin
               // Larger child moves up into the hole; descend.
               wr_data   = dn_big_val;
               pos_in    = dn_big[ADDR_W-1:0];
               moves_in  = moves_inc;
               rd_a_addr = dn_nl[ADDR_W-1:0];
               rd_b_addr = dn_nl[ADDR_W-1:0] + addr_type'(1);
            end
         end
         ST_PLACE: begin
            wr_en = 1'b1;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = '0;
               rsp_data_in[PORT_KEY_W-1:0] = PORT_KEY_W'(top_ff);
               rsp_data_in[PORT_KEY_W +: MOVES_W] = moves_ff;
               rsp_data_in[PORT_KEY_W + MOVES_W +: OCC_W] =
                  (count_ff > count_type'(255)) ? OCC_W'(255) : OCC_W'(count_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff      <= pos_in;
      key_ff      <= key_in;
      top_ff      <= top_in;
      moves_ff    <= moves_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

/* tb/max_heap_priority_queue_tb.sv */
`timescale 1ns / 1ps

module max_heap_priority_queue_tb;
   import mhpq_pkg::*;

   localparam int CLOCK_PERIOD  = 8;
   localparam int RESET_CYCLES  = 6;
   localparam int DIRECTED_ROWS = 21;
   localparam int RANDOM_ITEMS  = 500;
   localparam int MIX_ITEMS     = 60;
   localparam int FULL_EXTRA    = 6;
   localparam int EMPTY_EXTRA   = 4;
   localparam int HOLD_AFTER    = 150;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 20;
   localparam int CYCLE_LIMIT   = 300000;

   // One response beat, split into its fields.
   typedef struct packed {
      status_type  status;
      logic [31:0] removed_key;
      logic [2:0]  swap_moves;
      logic [7:0]  occupancy;
   } heap_result_t;

   // A row of the directed table. Where known is set, the result is taken
   // from the row; otherwise the heap predictor supplies it.
   typedef struct packed {
      op_type       op;
      logic [31:0]  key;
      logic         known;
      heap_result_t result;
   } stim_row_t;

   typedef enum logic [1:0] {
      TRAFFIC_MIX,
      TRAFFIC_FILL,
      TRAFFIC_DRAIN
   } traffic_mode_t;

   localparam heap_result_t NO_RESULT = '0;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   // Shadow copy of the heap, updated at each accepted request beat.
   key_type heap_keys [HEAP_CAPACITY];
   int      heap_size = 0;

   heap_result_t pending_results [$];
   int           mismatch_count = 0;
   int           results_seen   = 0;
   int           cycle_count    = 0;
   bit           tx_burst       = 1'b0;
   bit           rx_burst       = 1'b0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   max_heap_priority_queue i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Applies one request to the shadow heap and returns the response it yields.
   function automatic heap_result_t apply_request(op_type op, logic [31:0] key);
      heap_result_t res;
      int           pos;
      int           parent;
      int           left;
      int           right;
      int           big;
      int           moves;
      bit           settled;
      key_type      held;
      res     = NO_RESULT;
      moves   = 0;
      settled = 1'b0;
      if (op == OP_INSERT) begin
         if (heap_size >= HEAP_CAPACITY) begin
            res.status = STATUS_FULL;
         end else begin
            pos = heap_size;
            heap_keys[pos] = key_type'(key);
            heap_size++;
            // Climb while strictly greater than the parent.
            while (pos > 0 && !settled) begin
               parent = (pos - 1) / 2;
               if (heap_keys[pos] > heap_keys[parent]) begin
                  held              = heap_keys[pos];
                  heap_keys[pos]    = heap_keys[parent];
                  heap_keys[parent] = held;
                  pos = parent;
                  moves++;
               end else begin
                  settled = 1'b1;
               end
            end
         end
      end else if (heap_size == 0) begin
         res.status = STATUS_EMPTY;
      end else begin
         res.removed_key = heap_keys[0];
         heap_size--;
         if (heap_size > 0) begin
            heap_keys[0] = heap_keys[heap_size];
            pos = 0;
            // Sink toward the larger child; on equal children the left one is taken.
            while (!settled) begin
               left  = 2 * pos + 1;
               right = 2 * pos + 2;
               big   = pos;
               if (left < heap_size && heap_keys[left] > heap_keys[big]) big = left;
               if (right < heap_size && heap_keys[right] > heap_keys[big]) big = right;
               if (big == pos) begin
                  settled = 1'b1;
               end else begin
                  held           = heap_keys[pos];
                  heap_keys[pos] = heap_keys[big];
                  heap_keys[big] = held;
                  pos = big;
                  moves++;
               end
            end
         end
      end
      res.swap_moves = (moves > 7) ? 3'd7 : 3'(moves);
      res.occupancy  = (heap_size > 255) ? 8'd255 : 8'(heap_size);
      return res;
   endfunction

   // Always back to back in a burst; otherwise mostly back to back, often a short gap, now and then a long one.
   function automatic int pick_gap(bit burst);
      int roll;
      roll = $urandom_range(0, 99);
      if (burst || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Extremes, a narrow band around zero so that equal keys are common, and
   // full-range values.
   function automatic logic [31:0] random_key();
      case ($urandom_range(0, 9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'hffffffff;
         3, 4, 5: return $urandom_range(0, 16) - 32'd8;
         default: return $urandom;
      endcase
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Offers one request beat and records its result once it is accepted.
   task automatic offer_request(op_type op, logic [31:0] key, logic known,
                                heap_result_t known_result);
      int           gap;
      heap_result_t predicted;
      gap = pick_gap(tx_burst);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= key;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      predicted = apply_request(op, key);
      pending_results.push_back(known ? known_result : predicted);
   endtask

   // Stops offering and waits until every recorded result has come back.
   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Request side.
   initial begin
      stim_row_t     directed [DIRECTED_ROWS];
      traffic_mode_t mode;
      int            mode_left;
      int            spill;
      op_type        op;
      directed = '{
         // Empty heap right after reset, then the two extreme keys.
         '{OP_DELETE, 32'h5a5a5a5a, 1'b1, '{STATUS_EMPTY, 32'h0, 3'd0, 8'd0}},
         '{OP_INSERT, 32'h7fffffff, 1'b1, '{STATUS_OK, 32'h0, 3'd0, 8'd1}},
         '{OP_INSERT, 32'h80000000, 1'b1, '{STATUS_OK, 32'h0, 3'd0, 8'd2}},
         '{OP_DELETE, 32'h00000000, 1'b1, '{STATUS_OK, 32'h7fffffff, 3'd0, 8'd1}},
         // Removing the only key leaves the heap empty.
         '{OP_DELETE, 32'hffffffff, 1'b1, '{STATUS_OK, 32'h80000000, 3'd0, 8'd0}},
         '{OP_DELETE, 32'h00000000, 1'b1, '{STATUS_EMPTY, 32'h0, 3'd0, 8'd0}},
         // An equal key does not climb past its parent.
         '{OP_INSERT, 32'h00000000, 1'b1, '{STATUS_OK, 32'h0, 3'd0, 8'd1}},
         '{OP_INSERT, 32'h00000000, 1'b1, '{STATUS_OK, 32'h0, 3'd0, 8'd2}},
         // Rising keys climb several levels; the maximum key goes to the root.
         '{OP_INSERT, 32'h00000001, 1'b0, NO_RESULT},
         '{OP_INSERT, 32'h00000002, 1'b0, NO_RESULT},
         '{OP_INSERT, 32'h00000003, 1'b0, NO_RESULT},
         '{OP_INSERT, 32'h00000004, 1'b0, NO_RESULT},
         '{OP_INSERT, 32'h00000005, 1'b0, NO_RESULT},
         '{OP_INSERT, 32'hffffffff, 1'b0, NO_RESULT},
         '{OP_INSERT, 32'h7fffffff, 1'b0, NO_RESULT},
         '{OP_INSERT, 32'h80000000, 1'b0, NO_RESULT},
         // Deletes sink the last key through the tree.
         '{OP_DELETE, 32'h12345678, 1'b0, NO_RESULT},
         '{OP_DELETE, 32'h00000000, 1'b0, NO_RESULT},
         '{OP_DELETE, 32'hffffffff, 1'b0, NO_RESULT},
         '{OP_DELETE, 32'h00000000, 1'b0, NO_RESULT},
         '{OP_DELETE, 32'h00000000, 1'b0, NO_RESULT}
      };
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         offer_request(directed[i].op, directed[i].key, directed[i].known, directed[i].result);
      end
      wait_for_responses();

      // Random traffic cycles through a mixed stretch, a fill that runs into the
      // full heap, and a drain that runs into the empty heap.
      mode      = TRAFFIC_MIX;
      mode_left = MIX_ITEMS;
      spill     = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_ITEMS / 2) wait_for_responses();
         case (mode)
            TRAFFIC_MIX: begin
               op = ($urandom_range(0, 1) == 1) ? OP_DELETE : OP_INSERT;
               mode_left--;
               if (mode_left == 0) mode = TRAFFIC_FILL;
            end
            TRAFFIC_FILL: begin
               if (heap_size >= HEAP_CAPACITY) begin
                  op = OP_INSERT;
                  spill++;
               end else begin
                  op = ($urandom_range(0, 99) < 85) ? OP_INSERT : OP_DELETE;
               end
               if (spill == FULL_EXTRA) begin
                  spill = 0;
                  mode  = TRAFFIC_DRAIN;
               end
            end
            default: begin
               if (heap_size == 0) begin
                  op = OP_DELETE;
                  spill++;
               end else begin
                  op = ($urandom_range(0, 99) < 85) ? OP_DELETE : OP_INSERT;
               end
               if (spill == EMPTY_EXTRA) begin
                  spill     = 0;
                  mode      = TRAFFIC_MIX;
                  mode_left = MIX_ITEMS;
               end
            end
         endcase
         offer_request(op, random_key(), 1'b0, NO_RESULT);
      end

      wait_for_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Response side. Once, the receiver holds off for a long stretch so that the
   // block backs up and stops taking requests.
   initial begin
      int           gap;
      bit           held_off;
      heap_result_t want;
      held_off = 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (results_seen % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
         gap = pick_gap(rx_burst);
         if (!held_off && results_seen == HOLD_AFTER) begin
            held_off = 1'b1;
            gap      = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (rsp_tvalid !== 1'b1) @(posedge clock);
         results_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: response beat with nothing expected, tuser %h tdata %h",
                     $time, rsp_tuser, rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_tuser));
            check_field("removed_key", want.removed_key, rsp_tdata[31:0]);
            check_field("swap_moves", 32'(want.swap_moves), 32'(rsp_tdata[34:32]));
            check_field("occupancy", 32'(want.occupancy), 32'(rsp_tdata[42:35]));
            check_field("padding", 32'd0, 32'(rsp_tdata[47:43]));
         end
      end
   end

   // Guards against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

endmodule
